// ===== hw/rtl/whp_pkg.sv =====
// whp_pkg: shared widths, codes and stage structs for the wheel balance pid block
// no dependencies; imported by every module of the block

package whp_pkg;

   // ring depth default
   localparam int RING_DEPTH_DEFAULT = 8;

   // field widths
   localparam int DRIVE_W     = 3;
   localparam int COUNT_W     = 32;
   localparam int SPEED_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int CORR_W      = 48;
   localparam int ERR_W       = 32;
   localparam int DERIV_W     = ERR_W + 1;
   localparam int INTEG_W     = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // packed word widths
   localparam int REQ_DATA_W = 2 * COUNT_W + 2 * SPEED_W;
   localparam int RSP_DATA_W = 2 * SPEED_W + CORR_W;

   // drive mode code that enables the balancing loop
   localparam logic [DRIVE_W-1:0] DRIVE_FORWARD = 3'd1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_LEFT_LIMIT  = 3'd3,
      CSR_RIGHT_LIMIT = 3'd4
   } csr_index_type;

   // data that travels beside each word through the stages
   typedef struct packed {
      logic                      forward;
      logic signed [SPEED_W-1:0] left_cmd;
      logic signed [SPEED_W-1:0] right_cmd;
   } side_type;

   // one tick handed to the error history
   typedef struct packed {
      logic                    fire;
      logic                    forward;
      logic signed [ERR_W-1:0] err;
   } ring_step_type;

   // error terms of one tick
   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [DERIV_W-1:0] deriv;
      logic signed [INTEG_W-1:0] integ;
   } terms_type;

   // stage load strobes
   typedef struct packed {
      logic load_s2;
      logic load_s3;
      logic load_s4;
      logic load_out;
   } stage_load_type;

endpackage

// ===== hw/rtl/whp_ring.sv =====
// whp_ring: error history ring with slot index, previous slot tracking and term forming
// depends on whp_pkg

module whp_ring
   import whp_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  ring_step_type step,
   output terms_type     terms
);

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int SLOT_W = INTEG_W + ERR_W;

   logic [IDX_W-1:0]          ring_idx_ff;
   logic [IDX_W-1:0]          ring_idx_in;
   logic [IDX_W-1:0]          ring_idx_next;
   logic [SLOT_W-1:0]         slot_mem [RING_DEPTH];
   logic [SLOT_W-1:0]         slot_rd_ff;
   logic                      slot_rd_valid_ff;
   logic [RING_DEPTH-1:0]     slot_valid_ff;
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [ERR_W-1:0]   prev_err_in;
   logic signed [INTEG_W-1:0] prev_integ_ff;
   logic signed [INTEG_W-1:0] prev_integ_in;
   logic signed [INTEG_W-1:0] integ_new;
   logic signed [DERIV_W-1:0] deriv;
   logic                      slot_write;

   // slot index walks the ring on every tick
   assign ring_idx_next = (ring_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx_ff + 1'b1;
   assign ring_idx_in   = step.fire ? ring_idx_next : ring_idx_ff;
   assign slot_write    = step.fire && step.forward;

   // derivative and wrapping integral against the previous slot
   assign integ_new = prev_integ_ff + INTEG_W'(step.err);
   assign deriv     = DERIV_W'(step.err) - DERIV_W'(prev_err_ff);

   assign terms.err   = step.err;
   assign terms.deriv = deriv;
   assign terms.integ = integ_new;

   // previous slot for the next tick is the slot handled now
   always_comb begin
      prev_err_in   = prev_err_ff;
      prev_integ_in = prev_integ_ff;
      if (step.fire) begin
         if (step.forward) begin
            prev_err_in   = step.err;
            prev_integ_in = integ_new;
         end else if (slot_rd_valid_ff) begin
            prev_err_in   = slot_rd_ff[ERR_W-1:0];
            prev_integ_in = slot_rd_ff[SLOT_W-1:ERR_W];
         end else begin
            prev_err_in   = '0;
            prev_integ_in = '0;
         end
      end
   end

   // control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_idx_ff      <= '0;
         prev_err_ff      <= '0;
         prev_integ_ff    <= '0;
         slot_valid_ff    <= '0;
         slot_rd_valid_ff <= 1'b0;
      end else begin
         ring_idx_ff      <= ring_idx_in;
         prev_err_ff      <= prev_err_in;
         prev_integ_ff    <= prev_integ_in;
         slot_rd_valid_ff <= slot_valid_ff[ring_idx_in];
         if (slot_write) begin
            slot_valid_ff[ring_idx_ff] <= 1'b1;
         end
      end
   end

   // slot memory, read ahead at the next slot index
   always_ff @(posedge clock) begin
      if (slot_write) begin
         slot_mem[ring_idx_ff] <= {integ_new, step.err};
      end
      slot_rd_ff <= slot_mem[ring_idx_in];
   end

endmodule

// ===== hw/rtl/whp_mac.sv =====
// whp_mac: pid products, sum and 48-bit saturation over three register stages
// depends on whp_pkg

module whp_mac
   import whp_pkg::*;
(
   input  logic                      clock,
   input  stage_load_type            load,
   input  terms_type                 terms_in,
   input  side_type                  side_in,
   input  logic signed [GAIN_W-1:0]  gain_p,
   input  logic signed [GAIN_W-1:0]  gain_i,
   input  logic signed [GAIN_W-1:0]  gain_d,
   output logic signed [CORR_W-1:0]  corr,
   output side_type                  side_out
);

   localparam int PP_W  = GAIN_W + ERR_W;
   localparam int PI_W  = GAIN_W + INTEG_W;
   localparam int PD_W  = GAIN_W + DERIV_W;
   localparam int SUM_W = PI_W + 2;

   terms_type                 terms_ff;
   side_type                  side2_ff;
   logic signed [PP_W-1:0]    pp_ff;
   logic signed [PP_W-1:0]    pp_in;
   logic signed [PI_W-1:0]    pi_ff;
   logic signed [PI_W-1:0]    pi_in;
   logic signed [PD_W-1:0]    pd_ff;
   logic signed [PD_W-1:0]    pd_in;
   side_type                  side3_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [CORR_W-1:0]  corr_sat;
   logic signed [CORR_W-1:0]  corr_in;
   logic signed [CORR_W-1:0]  corr_ff;
   side_type                  side4_ff;

   // products
   assign pp_in = gain_p * terms_ff.err;
   assign pi_in = gain_i * terms_ff.integ;
   assign pd_in = gain_d * terms_ff.deriv;

   // sum and clamp to the correction range
   assign sum = SUM_W'(pp_ff) + SUM_W'(pi_ff) + SUM_W'(pd_ff);

   always_comb begin
      if ((&sum[SUM_W-1:CORR_W-1]) || !(|sum[SUM_W-1:CORR_W-1])) begin
         corr_sat = sum[CORR_W-1:0];
      end else if (sum[SUM_W-1]) begin
         corr_sat = {1'b1, {(CORR_W-1){1'b0}}};
      end else begin
         corr_sat = {1'b0, {(CORR_W-1){1'b1}}};
      end
   end

   assign corr_in = side3_ff.forward ? corr_sat : '0;

   // stage registers
   always_ff @(posedge clock) begin
      if (load.load_s2) begin
         terms_ff <= terms_in;
         side2_ff <= side_in;
      end
      if (load.load_s3) begin
         pp_ff    <= pp_in;
         pi_ff    <= pi_in;
         pd_ff    <= pd_in;
         side3_ff <= side2_ff;
      end
      if (load.load_s4) begin
         corr_ff  <= corr_in;
         side4_ff <= side3_ff;
      end
   end

   assign corr     = corr_ff;
   assign side_out = side4_ff;

endmodule

// ===== hw/rtl/whp_steer.sv =====
// whp_steer: applies the correction to one wheel within its limit, saturates, registers result
// depends on whp_pkg

module whp_steer
   import whp_pkg::*;
(
   input  logic                      clock,
   input  logic                      load_out,
   input  logic signed [CORR_W-1:0]  corr_in,
   input  side_type                  side_in,
   input  logic [LIMIT_W-1:0]        left_limit,
   input  logic [LIMIT_W-1:0]        right_limit,
   output logic signed [SPEED_W-1:0] left_cmd_out,
   output logic signed [SPEED_W-1:0] right_cmd_out,
   output logic signed [CORR_W-1:0]  correction
);

   localparam int WIDE_W = CORR_W + 2;

   logic signed [WIDE_W-1:0]  wide_left;
   logic signed [WIDE_W-1:0]  wide_right;
   logic signed [WIDE_W-1:0]  wide_corr;
   logic signed [WIDE_W-1:0]  lim_left;
   logic signed [WIDE_W-1:0]  lim_right;
   logic signed [WIDE_W-1:0]  left_plus;
   logic signed [WIDE_W-1:0]  left_minus;
   logic signed [WIDE_W-1:0]  right_plus;
   logic signed [WIDE_W-1:0]  right_minus;
   logic signed [WIDE_W-1:0]  new_left;
   logic signed [WIDE_W-1:0]  new_right;
   logic signed [SPEED_W-1:0] left_ff;
   logic signed [SPEED_W-1:0] right_ff;
   logic signed [CORR_W-1:0]  corr_ff;
   logic                      corr_pos;
   logic                      corr_neg;

   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if ((&v[WIDE_W-1:SPEED_W-1]) || !(|v[WIDE_W-1:SPEED_W-1])) begin
         r = v[SPEED_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SPEED_W-1){1'b1}}};
      end
      return r;
   endfunction

   // candidate speeds side by side
   assign wide_left   = WIDE_W'(side_in.left_cmd);
   assign wide_right  = WIDE_W'(side_in.right_cmd);
   assign wide_corr   = WIDE_W'(corr_in);
   assign lim_left    = WIDE_W'(left_limit);
   assign lim_right   = WIDE_W'(right_limit);
   assign left_plus   = wide_left + wide_corr;
   assign left_minus  = wide_left - wide_corr;
   assign right_plus  = wide_right + wide_corr;
   assign right_minus = wide_right - wide_corr;
   assign corr_neg    = corr_in[CORR_W-1];
   assign corr_pos    = !corr_in[CORR_W-1] && (corr_in != '0);

   // left (corr > 0) or right (corr < 0) gets +corr if in limit, else the other gets -corr
   always_comb begin
      new_left  = wide_left;
      new_right = wide_right;
      if (corr_pos) begin
         if (left_plus <= lim_left) begin
            new_left = left_plus;
         end else begin
            new_right = right_minus;
         end
      end else if (corr_neg) begin
         if (right_plus <= lim_right) begin
            new_right = right_plus;
         end else begin
            new_left = left_minus;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         left_ff  <= sat_speed(new_left);
         right_ff <= sat_speed(new_right);
         corr_ff  <= corr_in;
      end
   end

   assign left_cmd_out  = left_ff;
   assign right_cmd_out = right_ff;
   assign correction    = corr_ff;

endmodule

// ===== hw/rtl/wheel_balance_pid.sv =====
// wheel_balance_pid: top level with config registers, input register and stage handshake
// depends on whp_pkg, whp_ring, whp_mac, whp_steer

// Encoder balancing PID for a two-wheel drive. Each request word carries the drive
// state, both encoder counts and the current speed commands; each response word
// carries the adjusted speeds and the correction. The block takes one word per clock
// cycle when the response side keeps up; each accepted request passes through the input
// register, terms, products, sum and clamp, and result register before its response appears.
// The one-cycle rate is set by the error history update, which forms the new error,
// derivative and integral from the previous slot combinationally. The history ring
// holds RING_DEPTH slots in a memory with one valid flop per slot cleared by reset, so
// no clearing pass is needed. The ring slot advances on every word; only forward drive
// words write the ring and produce a nonzero correction. The user must write registers
// only while no word is in flight; the block itself does not enforce this.

module wheel_balance_pid
   import whp_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // left count, right count, left wheel command, right wheel command
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // drive mode
   input  logic [DRIVE_W-1:0]     req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // adjusted left command, adjusted right command, correction
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic signed [GAIN_W-1:0]  gain_p_ff;
   logic signed [GAIN_W-1:0]  gain_i_ff;
   logic signed [GAIN_W-1:0]  gain_d_ff;
   logic [LIMIT_W-1:0]        left_limit_ff;
   logic [LIMIT_W-1:0]        right_limit_ff;

   logic                      v1_ff, v1_in;
   logic                      v2_ff, v2_in;
   logic                      v3_ff, v3_in;
   logic                      v4_ff, v4_in;
   logic                      out_v_ff, out_v_in;
   logic                      rdy1, rdy2, rdy3, rdy4, rdy_out;
   logic                      fire0, fire1, fire2, fire3, fire4;

   logic [COUNT_W-1:0]        req_left_count;
   logic [COUNT_W-1:0]        req_right_count;
   logic signed [ERR_W-1:0]   s1_err_ff;
   side_type                  s1_side_ff;
   ring_step_type             ring_step;
   terms_type                 terms;
   stage_load_type            load;
   logic signed [CORR_W-1:0]  s4_corr;
   side_type                  s4_side;
   logic signed [SPEED_W-1:0] left_cmd_out;
   logic signed [SPEED_W-1:0] right_cmd_out;
   logic signed [CORR_W-1:0]  correction;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         left_limit_ff  <= '1;
         right_limit_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:      gain_p_ff      <= csr_wdata;
            CSR_GAIN_I:      gain_i_ff      <= csr_wdata;
            CSR_GAIN_D:      gain_d_ff      <= csr_wdata;
            CSR_LEFT_LIMIT:  left_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_RIGHT_LIMIT: right_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage handshake, a stage loads when the one after it frees up
   assign rdy_out = !out_v_ff || rsp_tready;
   assign rdy4    = !v4_ff || rdy_out;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;
   assign fire0   = req_tvalid && rdy1;
   assign fire1   = v1_ff && rdy2;
   assign fire2   = v2_ff && rdy3;
   assign fire3   = v3_ff && rdy4;
   assign fire4   = v4_ff && rdy_out;

   assign v1_in    = fire0 || (v1_ff && !fire1);
   assign v2_in    = fire1 || (v2_ff && !fire2);
   assign v3_in    = fire2 || (v3_ff && !fire3);
   assign v4_in    = fire3 || (v4_ff && !fire4);
   assign out_v_in = fire4 || (out_v_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         out_v_ff <= out_v_in;
      end
   end

   // input register, count error formed on the way in
   assign req_left_count  = req_tdata[COUNT_W-1:0];
   assign req_right_count = req_tdata[2*COUNT_W-1:COUNT_W];

   always_ff @(posedge clock) begin
      if (fire0) begin
         s1_err_ff            <= req_right_count - req_left_count;
         s1_side_ff.forward   <= (req_tuser == DRIVE_FORWARD);
         s1_side_ff.left_cmd  <= req_tdata[2*COUNT_W+SPEED_W-1:2*COUNT_W];
         s1_side_ff.right_cmd <= req_tdata[REQ_DATA_W-1:2*COUNT_W+SPEED_W];
      end
   end

   // error history
   assign ring_step.fire    = fire1;
   assign ring_step.forward = s1_side_ff.forward;
   assign ring_step.err     = s1_err_ff;

   whp_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .step  (ring_step),
      .terms (terms)
   );

   // products, sum and clamp
   assign load.load_s2  = fire1;
   assign load.load_s3  = fire2;
   assign load.load_s4  = fire3;
   assign load.load_out = fire4;

   whp_mac u_mac (
      .clock    (clock),
      .load     (load),
      .terms_in (terms),
      .side_in  (s1_side_ff),
      .gain_p   (gain_p_ff),
      .gain_i   (gain_i_ff),
      .gain_d   (gain_d_ff),
      .corr     (s4_corr),
      .side_out (s4_side)
   );

   // speed adjust and result register
   whp_steer u_steer (
      .clock         (clock),
      .load_out      (load.load_out),
      .corr_in       (s4_corr),
      .side_in       (s4_side),
      .left_limit    (left_limit_ff),
      .right_limit   (right_limit_ff),
      .left_cmd_out  (left_cmd_out),
      .right_cmd_out (right_cmd_out),
      .correction    (correction)
   );

   assign req_tready = rdy1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {correction, right_cmd_out, left_cmd_out};

`ifndef SYNTH
   // words outside forward drive leave with zero correction
   a_idle_corr_zero: assert property (@(posedge clock) disable iff (reset)
      (fire4 && !s4_side.forward) |=> (rsp_tdata[RSP_DATA_W-1:2*SPEED_W] == '0))
      else $error("nonzero correction outside forward drive");

   // words outside forward drive pass their speeds unchanged
   a_idle_pass: assert property (@(posedge clock) disable iff (reset)
      (fire4 && !s4_side.forward) |=>
         ((rsp_tdata[SPEED_W-1:0] == $past(s4_side.left_cmd)) &&
          (rsp_tdata[2*SPEED_W-1:SPEED_W] == $past(s4_side.right_cmd))))
      else $error("speeds changed outside forward drive");

   // a response only appears behind a filled last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v4_ff))
      else $error("response valid without a word in the last stage");

   // a stalled input word keeps its place and its error
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !fire1) |=> (v1_ff && $stable(s1_err_ff)))
      else $error("input register lost a stalled word");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for wheel_balance_pid, a directed table then random phases
// depends on whp_pkg and the wheel_balance_pid rtl; the predictor or table row checks each response

module tb;
   import whp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASES          = 6;
   localparam int PHASE_WORDS     = 72;
   localparam int SETTLE_CYCLES   = 8;

   localparam longint CORR_HI  = (64'sd1 <<< (CORR_W - 1)) - 64'sd1;
   localparam longint CORR_LO  = -(64'sd1 <<< (CORR_W - 1));
   localparam longint SPEED_HI = 32767;
   localparam longint SPEED_LO = -32768;

   localparam logic [DRIVE_W-1:0]     DRIVE_STOPPED   = 3'd0;
   localparam logic [DRIVE_W-1:0]     DRIVE_LAST      = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef enum logic {ROW_TICK, ROW_REG} row_kind_type;
   typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_PATTERN} rsp_mode_type;

   typedef struct {
      logic [DRIVE_W-1:0]        drive;
      logic [COUNT_W-1:0]        left_count;
      logic [COUNT_W-1:0]        right_count;
      logic signed [SPEED_W-1:0] left_cmd;
      logic signed [SPEED_W-1:0] right_cmd;
   } tick_type;

   typedef struct {
      logic signed [SPEED_W-1:0] left_cmd;
      logic signed [SPEED_W-1:0] right_cmd;
      logic signed [CORR_W-1:0]  correction;
   } wheel_cmd_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      tick_type               tick;
      bit                     known;
      wheel_cmd_type          cmd;
   } row_type;

   // block ports, all inputs known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // left count, right count, left wheel command, right wheel command
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // drive mode
   logic [DRIVE_W-1:0]     req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // adjusted left command, adjusted right command, correction
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // predictor copy of registers and error history
   longint             gain_p      = 0;
   longint             gain_i      = 0;
   longint             gain_d      = 0;
   longint             left_limit  = 32767;
   longint             right_limit = 32767;
   logic [ERR_W-1:0]   err_hist   [RING_DEPTH_DEFAULT] = '{default: '0};
   logic [INTEG_W-1:0] integ_hist [RING_DEPTH_DEFAULT] = '{default: '0};
   int                 slot = 0;

   wheel_cmd_type pending_cmds[$];
   row_type       directed_rows[$];
   int            mismatches = 0;
   int            idle_cycles = 0;

   // sender and receiver pacing
   bit                 req_idle_on   = 1'b1;
   int                 burst_left    = 0;
   rsp_mode_type       rsp_mode      = RSP_RANDOM;
   int                 hold_requests = 0;
   int                 hold_served   = 0;
   int                 hold_left     = 0;
   int                 pattern_phase = 0;
   logic [COUNT_W-1:0] odometer      = '0;

   wheel_balance_pid dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // register write as seen by the predictor; unmapped indexes are dropped
   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_GAIN_P:      gain_p = longint'($signed(value));
         CSR_GAIN_I:      gain_i = longint'($signed(value));
         CSR_GAIN_D:      gain_d = longint'($signed(value));
         CSR_LEFT_LIMIT:  left_limit = longint'(value[LIMIT_W-1:0]);
         CSR_RIGHT_LIMIT: right_limit = longint'(value[LIMIT_W-1:0]);
         default: ;
      endcase
   endfunction

   // one control tick: pid on the encoder error, then steer one wheel
   function automatic wheel_cmd_type balance_tick(tick_type t);
      wheel_cmd_type      cmd;
      int                 prev;
      logic [ERR_W-1:0]   err_bits;
      logic [INTEG_W-1:0] integ_bits;
      longint             err, deriv, integ, corr, left, right;
      left  = longint'(t.left_cmd);
      right = longint'(t.right_cmd);
      corr  = 0;
      if (t.drive == DRIVE_FORWARD) begin
         prev       = (slot == 0) ? RING_DEPTH_DEFAULT - 1 : slot - 1;
         err_bits   = t.right_count - t.left_count;
         err        = longint'($signed(err_bits));
         deriv      = err - longint'($signed(err_hist[prev]));
         integ_bits = integ_hist[prev] + INTEG_W'(err);
         integ      = longint'($signed(integ_bits));
         err_hist[slot]   = err_bits;
         integ_hist[slot] = integ_bits;
         corr = clamp(gain_p * err + gain_i * integ + gain_d * deriv, CORR_LO, CORR_HI);
         // positive: speed up left or slow right; negative: slow right or speed up left
         if (corr > 0) begin
            if (left + corr <= left_limit) left += corr;
            else right -= corr;
         end else if (corr < 0) begin
            if (right + corr <= right_limit) right += corr;
            else left -= corr;
         end
         left  = clamp(left, SPEED_LO, SPEED_HI);
         right = clamp(right, SPEED_LO, SPEED_HI);
      end
      slot = (slot == RING_DEPTH_DEFAULT - 1) ? 0 : slot + 1;
      cmd.left_cmd   = SPEED_W'(left);
      cmd.right_cmd  = SPEED_W'(right);
      cmd.correction = CORR_W'(corr);
      return cmd;
   endfunction

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   function automatic void add_tick(logic [DRIVE_W-1:0] drive, logic [COUNT_W-1:0] lc,
                                    logic [COUNT_W-1:0] rc, logic signed [SPEED_W-1:0] ls,
                                    logic signed [SPEED_W-1:0] rs, bit known,
                                    logic signed [SPEED_W-1:0] exp_l,
                                    logic signed [SPEED_W-1:0] exp_r);
      row_type r;
      r.kind  = ROW_TICK;
      r.index = '0;
      r.value = '0;
      r.tick  = '{drive, lc, rc, ls, rs};
      r.known = known;
      r.cmd   = '{exp_l, exp_r, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      row_type r;
      r.kind  = ROW_REG;
      r.index = index;
      r.value = value;
      r.tick  = '{'0, '0, '0, '0, '0};
      r.known = 1'b0;
      r.cmd   = '{'0, '0, '0};
      directed_rows.push_back(r);
   endfunction

   // mostly a moving odometer with a small left/right skew, some noise words
   function automatic tick_type random_tick();
      tick_type t;
      int       pick;
      pick = $urandom_range(0, 99);
      odometer += $urandom_range(0, 300);
      t.drive       = DRIVE_FORWARD;
      t.left_count  = odometer;
      t.right_count = odometer + COUNT_W'($urandom_range(0, 400)) - 32'd200;
      if (pick >= 90) begin
         t.left_count  = $urandom;
         t.right_count = $urandom;
      end else if (pick >= 75) begin
         t.drive = DRIVE_W'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 1)) begin
         t.left_cmd  = SPEED_W'($urandom);
         t.right_cmd = SPEED_W'($urandom);
      end else begin
         t.left_cmd  = SPEED_W'($urandom_range(0, 4000)) - 16'sd2000;
         t.right_cmd = SPEED_W'($urandom_range(0, 4000)) - 16'sd2000;
      end
      return t;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain(int phase);
      if (phase == 1) begin
         case ($urandom_range(0, 2))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'h0000;
         endcase
      end
      if (phase % 2 == 0) return CSR_DATA_W'($urandom_range(0, 256)) - 16'd128;
      return CSR_DATA_W'($urandom);
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offer one word, with a random gap between bursts, and log its expected result
   task automatic send_tick(tick_type t, bit known, wheel_cmd_type cmd);
      wheel_cmd_type predicted;
      int            gap;
      if (req_idle_on && burst_left == 0) begin
         gap        = $urandom_range(1, 10);
         burst_left = $urandom_range(1, 20);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= t.drive;
      req_tdata  <= {t.right_cmd, t.left_cmd, t.right_count, t.left_count};
      do @(posedge clock); while (!req_tready);
      predicted = balance_tick(t);
      pending_cmds.push_back(known ? cmd : predicted);
   endtask

   // stop offering and wait for the block to drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: long hold-off on request, otherwise its own ready pattern
   always @(negedge clock) begin
      logic ready;
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready = 1'b0;
      end else begin
         case (rsp_mode)
            RSP_ALWAYS: ready = 1'b1;
            RSP_RANDOM: ready = ($urandom_range(0, 3) != 0);
            default: begin
               pattern_phase = (pattern_phase + 1) % 7;
               ready = (pattern_phase < 4);
            end
         endcase
      end
      rsp_tready <= ready;
   end

   // response checker
   always @(posedge clock) begin
      wheel_cmd_type want;
      wheel_cmd_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_cmd   = rsp_tdata[SPEED_W-1:0];
         got.right_cmd  = rsp_tdata[2*SPEED_W-1:SPEED_W];
         got.correction = rsp_tdata[RSP_DATA_W-1:2*SPEED_W];
         if (pending_cmds.size() == 0) begin
            flag_mismatch($sformatf("word with nothing pending: left %0d right %0d corr %0d",
                                    got.left_cmd, got.right_cmd, got.correction));
         end else begin
            want = pending_cmds.pop_front();
            if (got.left_cmd !== want.left_cmd || got.right_cmd !== want.right_cmd ||
                got.correction !== want.correction)
               flag_mismatch($sformatf(
                  "left %0d/%0d right %0d/%0d corr %0d/%0d (expected/actual)",
                  want.left_cmd, got.left_cmd, want.right_cmd, got.right_cmd,
                  want.correction, got.correction));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      wheel_cmd_type none;
      none     = '{'0, '0, '0};
      odometer = $urandom;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero gains after reset: every word passes its speeds through
      add_tick(DRIVE_STOPPED, 32'h0, 32'h0, 16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF);
      add_tick(DRIVE_FORWARD, 32'hFFFF_FFFF, 32'h0, 16'sh7FFF, 16'sh8000, 1,
               16'sh7FFF, 16'sh8000);
      for (int s = 2; s <= DRIVE_LAST; s++)
         add_tick(DRIVE_W'(s), 32'h0, 32'hFFFF_FFFF, 16'sd1234, -16'sd1234, 1,
                  16'sd1234, -16'sd1234);
      // writes to unmapped indexes must not touch the gains
      add_reg(CSR_UNMAPPED_LO, 16'hFFFF);
      add_reg(CSR_UNMAPPED_HI, 16'hFFFF);
      add_tick(DRIVE_FORWARD, 32'd5, 32'd9, 16'sd100, -16'sd100, 1, 16'sd100, -16'sd100);
      // largest gains: error swings end to end, correction saturates both ways
      add_reg(CSR_GAIN_P, 16'h7FFF);
      add_reg(CSR_GAIN_I, 16'h0000);
      add_reg(CSR_GAIN_D, 16'h7FFF);
      add_tick(DRIVE_FORWARD, 32'h8000_0000, 32'h0, 16'sd0, 16'sd0, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'h0, 32'h7FFF_FFFF, 16'sh8000, 16'sh7FFF, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 0, '0, '0);
      add_reg(CSR_GAIN_P, 16'h8000);
      add_reg(CSR_GAIN_I, 16'h7FFF);
      add_reg(CSR_GAIN_D, 16'h8000);
      add_tick(DRIVE_FORWARD, 32'h0, 32'h7FFF_FFFF, 16'sd0, 16'sd0, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'h0, 32'h7FFF_FFFF, 16'sd300, -16'sd300, 0, '0, '0);
      // zero limits: a left raise past the limit falls back to slowing the right, a right slowdown to raising the left
      add_reg(CSR_LEFT_LIMIT, 16'h0000);
      add_reg(CSR_RIGHT_LIMIT, 16'h0000);
      add_reg(CSR_GAIN_P, 16'h0001);
      add_reg(CSR_GAIN_I, 16'h0000);
      add_reg(CSR_GAIN_D, 16'h0000);
      add_tick(DRIVE_FORWARD, 32'd0, 32'd10, 16'sd5, 16'sd50, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'd10, 32'd0, 16'sd5, -16'sd50, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'd10, 32'd0, 16'sd5, 16'sd50, 0, '0, '0);
      // full limits with the top bit set, speeds driven into saturation
      add_reg(CSR_LEFT_LIMIT, 16'hFFFF);
      add_reg(CSR_RIGHT_LIMIT, 16'h7FFF);
      add_tick(DRIVE_FORWARD, 32'd0, 32'd3, 16'sh7FFF, 16'sh7FFF, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'd0, 32'd40000, 16'sd32000, 16'sd0, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'd40000, 32'd0, 16'sd0, -16'sd32000, 0, '0, '0);
      add_tick(DRIVE_FORWARD, 32'd7, 32'd7, 16'sd77, -16'sd77, 0, '0, '0);

      // walk the table
      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_REG) begin
            if (k > 0 && directed_rows[k-1].kind == ROW_TICK) settle();
            write_reg(directed_rows[k].index, directed_rows[k].value);
         end else begin
            send_tick(directed_rows[k].tick, directed_rows[k].known, directed_rows[k].cmd);
         end
      end
      settle();

      // random phases, each with its own gains, limits and pacing
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_GAIN_P, pick_gain(p));
         write_reg(CSR_GAIN_I, pick_gain(p));
         write_reg(CSR_GAIN_D, pick_gain(p));
         write_reg(CSR_LEFT_LIMIT, (p == 1) ? 16'h0000 : (p == 3) ? 16'hFFFF
                                   : CSR_DATA_W'($urandom));
         write_reg(CSR_RIGHT_LIMIT, (p == 1) ? 16'h0000 : (p == 3) ? 16'h7FFF
                                    : CSR_DATA_W'($urandom));
         write_reg(CSR_INDEX_W'(CSR_UNMAPPED_LO + p % 3), CSR_DATA_W'($urandom));
         rsp_mode    = rsp_mode_type'(p % 3);
         req_idle_on = (p != 4);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // receiver holds off while the sender keeps pushing
            if (p == 1 && i == 20) begin
               hold_requests++;
               req_idle_on = 1'b0;
            end
            if (p == 1 && i == 50) req_idle_on = 1'b1;
            // sender pauses until the block is empty
            if (p == 2 && i == PHASE_WORDS / 2) settle();
            send_tick(random_tick(), 0, none);
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
